>>> src/fgm_pkg.sv
// Shared types, constants and helpers for the filtered group max selector.
package fgm_pkg;

    localparam int MEMBER_DEPTH = 1024;
    localparam int GROUP_DEPTH  = 1024;
    localparam int COR_BITS     = 16;
    localparam int ID_BITS      = 31;
    localparam int SLOT_BITS    = 10;

    localparam int MIDX_W = (MEMBER_DEPTH > 1) ? $clog2(MEMBER_DEPTH) : 1;
    localparam int GIDX_W = (GROUP_DEPTH > 1) ? $clog2(GROUP_DEPTH) : 1;
    localparam int MCNT_W = $clog2(MEMBER_DEPTH + 1);
    localparam int GCNT_W = $clog2(GROUP_DEPTH + 1);
    localparam int SCAN_W = (MCNT_W > GCNT_W) ? MCNT_W : GCNT_W;

    localparam int IN_BITS  = 2 + 2 * ID_BITS + COR_BITS + SLOT_BITS;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 2 + 1 + 2 * ID_BITS + COR_BITS + GCNT_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_REC  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FILTERED = 2'd1;
    localparam logic [1:0] STAT_GFULL    = 2'd2;
    localparam logic [1:0] STAT_MFULL    = 2'd3;

    typedef enum logic [1:0] {
        KIND_LOAD,
        KIND_REC,
        KIND_READ,
        KIND_NOP
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MSCAN,
        ST_GSCAN,
        ST_READ
    } state_t;

    typedef struct packed {
        kind_t                 kind;
        logic [ID_BITS-1:0]    fst;
        logic [ID_BITS-1:0]    snd;
        logic [COR_BITS-1:0]   cor;
        logic [SLOT_BITS-1:0]  slot;
    } item_t;

    // Magnitude of a two's complement code, read as unsigned.
    function automatic logic [COR_BITS-1:0] cor_mag(input logic [COR_BITS-1:0] c);
        cor_mag = c[COR_BITS-1] ? (~c + COR_BITS'(1)) : c;
    endfunction

endpackage

>>> src/fgm_front.sv
// Front end: unpacks an input transfer and classifies it by opcode.
module fgm_front (
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [fgm_pkg::IN_W-1:0]  s_tdata,
    input  logic                      q_full,
    output logic                      q_push,
    output fgm_pkg::item_t            q_item
);
    logic [1:0] op;

    assign op       = s_tdata[1:0];
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        unique case (op)
            fgm_pkg::OP_LOAD: q_item.kind = fgm_pkg::KIND_LOAD;
            fgm_pkg::OP_REC:  q_item.kind = fgm_pkg::KIND_REC;
            fgm_pkg::OP_READ: q_item.kind = fgm_pkg::KIND_READ;
            default:          q_item.kind = fgm_pkg::KIND_NOP;
        endcase
        q_item.fst  = s_tdata[2 +: fgm_pkg::ID_BITS];
        q_item.snd  = s_tdata[2 + fgm_pkg::ID_BITS +: fgm_pkg::ID_BITS];
        q_item.cor  = s_tdata[2 + 2 * fgm_pkg::ID_BITS +: fgm_pkg::COR_BITS];
        q_item.slot = s_tdata[2 + 2 * fgm_pkg::ID_BITS + fgm_pkg::COR_BITS +:
                              fgm_pkg::SLOT_BITS];
    end
endmodule

>>> src/fgm_fifo.sv
// Two-entry queue between front end and engine.
module fgm_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  fgm_pkg::item_t  push_item,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output fgm_pkg::item_t  pop_item
);
    fgm_pkg::item_t slots_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_item  = slots_reg[rptr_reg];

    always_comb begin
        wptr_next  = wptr_reg ^ push;
        rptr_next  = rptr_reg ^ pop;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wptr_reg] <= push_item;
        end
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end
endmodule

>>> src/fgm_engine.sv
// Back end: member set and group table memories, scan sequencer, result register.
module fgm_engine (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       q_valid,
    input  fgm_pkg::item_t             q_item,
    output logic                       q_pop,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [fgm_pkg::OUT_W-1:0]  m_tdata
);
    localparam int SW = fgm_pkg::SCAN_W;

    fgm_pkg::state_t state_reg, state_next;
    fgm_pkg::item_t  item_reg;
    logic [SW-1:0]   idx_reg, pidx_reg;
    logic            pend_reg;
    logic [fgm_pkg::MCNT_W-1:0] mcount_reg;
    logic [fgm_pkg::GCNT_W-1:0] gcount_reg, gcount_next;

    // memories
    logic [fgm_pkg::ID_BITS-1:0]  mem_ids  [fgm_pkg::MEMBER_DEPTH];
    logic [fgm_pkg::ID_BITS-1:0]  mem_keys [fgm_pkg::GROUP_DEPTH];
    logic [fgm_pkg::ID_BITS-1:0]  mem_parts[fgm_pkg::GROUP_DEPTH];
    logic [fgm_pkg::COR_BITS-1:0] mem_vals [fgm_pkg::GROUP_DEPTH];
    logic [fgm_pkg::ID_BITS-1:0]  mid_rd_reg, gkey_rd_reg, gpart_rd_reg;
    logic [fgm_pkg::COR_BITS-1:0] gval_rd_reg;
    logic [fgm_pkg::GIDX_W-1:0]   g_raddr;

    // control
    logic       m_hit, m_end, g_hit, g_end, in_range;
    logic       issue, scan_clr, done, done_valid, m_we, g_new, g_upd;
    logic [1:0] done_status;

    logic                         out_valid_reg;
    logic [1:0]                   out_status_reg;
    logic                         out_slot_valid_reg;
    logic [fgm_pkg::ID_BITS-1:0]  out_fst_reg, out_snd_reg;
    logic [fgm_pkg::COR_BITS-1:0] out_cor_reg;
    logic [fgm_pkg::GCNT_W-1:0]   out_groups_reg;

    assign m_hit    = pend_reg && (mid_rd_reg == item_reg.snd);
    assign m_end    = !pend_reg && (idx_reg == SW'(mcount_reg));
    assign g_hit    = pend_reg && (gkey_rd_reg == item_reg.fst);
    assign g_end    = !pend_reg && (idx_reg == SW'(gcount_reg));
    assign in_range = 32'(item_reg.slot) < 32'(gcount_reg);

    always_comb begin
        q_pop       = 1'b0;
        issue       = 1'b0;
        scan_clr    = 1'b0;
        done        = 1'b0;
        done_valid  = 1'b0;
        done_status = fgm_pkg::STAT_OK;
        m_we        = 1'b0;
        g_new       = 1'b0;
        g_upd       = 1'b0;
        unique case (state_reg)
            fgm_pkg::ST_IDLE: begin
                q_pop    = q_valid && !out_valid_reg;
                scan_clr = 1'b1;
                done     = q_pop && (q_item.kind == fgm_pkg::KIND_NOP);
            end
            fgm_pkg::ST_MSCAN: begin
                issue = !m_hit && (idx_reg < SW'(mcount_reg));
                if (m_hit) begin
                    if (item_reg.kind == fgm_pkg::KIND_REC) begin
                        scan_clr = 1'b1;
                    end else begin
                        done = 1'b1;
                    end
                end else if (m_end) begin
                    done = 1'b1;
                    if (item_reg.kind == fgm_pkg::KIND_REC) begin
                        done_status = fgm_pkg::STAT_FILTERED;
                    end else if (32'(mcount_reg) == fgm_pkg::MEMBER_DEPTH) begin
                        done_status = fgm_pkg::STAT_MFULL;
                    end else begin
                        m_we = 1'b1;
                    end
                end
            end
            fgm_pkg::ST_GSCAN: begin
                issue = !g_hit && (idx_reg < SW'(gcount_reg));
                if (g_hit) begin
                    done  = 1'b1;
                    g_upd = fgm_pkg::cor_mag(item_reg.cor) > fgm_pkg::cor_mag(gval_rd_reg);
                end else if (g_end) begin
                    done = 1'b1;
                    if (32'(gcount_reg) == fgm_pkg::GROUP_DEPTH) begin
                        done_status = fgm_pkg::STAT_GFULL;
                    end else begin
                        g_new = 1'b1;
                    end
                end
            end
            fgm_pkg::ST_READ: begin
                if (pend_reg) begin
                    done       = 1'b1;
                    done_valid = 1'b1;
                end else begin
                    issue = in_range;
                    done  = !in_range;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fgm_pkg::ST_IDLE: begin
                if (q_pop) begin
                    unique case (q_item.kind) inside
                        fgm_pkg::KIND_LOAD, fgm_pkg::KIND_REC: state_next = fgm_pkg::ST_MSCAN;
                        fgm_pkg::KIND_READ: state_next = fgm_pkg::ST_READ;
                        default:            state_next = fgm_pkg::ST_IDLE;
                    endcase
                end
            end
            fgm_pkg::ST_MSCAN: begin
                if (done) begin
                    state_next = fgm_pkg::ST_IDLE;
                end else if (scan_clr) begin
                    state_next = fgm_pkg::ST_GSCAN;
                end
            end
            default: begin
                if (done) begin
                    state_next = fgm_pkg::ST_IDLE;
                end
            end
        endcase
    end

    assign gcount_next = gcount_reg + fgm_pkg::GCNT_W'(g_new);
    assign g_raddr = (state_reg == fgm_pkg::ST_READ) ? fgm_pkg::GIDX_W'(item_reg.slot)
                                                     : idx_reg[fgm_pkg::GIDX_W-1:0];

    // member set
    always_ff @(posedge aclk) begin
        if (m_we) begin
            mem_ids[mcount_reg[fgm_pkg::MIDX_W-1:0]] <= item_reg.snd;
        end
        mid_rd_reg <= mem_ids[idx_reg[fgm_pkg::MIDX_W-1:0]];
    end

    // group table
    always_ff @(posedge aclk) begin
        if (g_new) begin
            mem_keys[gcount_reg[fgm_pkg::GIDX_W-1:0]] <= item_reg.fst;
        end
        gkey_rd_reg <= mem_keys[g_raddr];
    end

    always_ff @(posedge aclk) begin
        if (g_new) begin
            mem_parts[gcount_reg[fgm_pkg::GIDX_W-1:0]] <= item_reg.snd;
        end else if (g_upd) begin
            mem_parts[pidx_reg[fgm_pkg::GIDX_W-1:0]] <= item_reg.snd;
        end
        gpart_rd_reg <= mem_parts[g_raddr];
    end

    always_ff @(posedge aclk) begin
        if (g_new) begin
            mem_vals[gcount_reg[fgm_pkg::GIDX_W-1:0]] <= item_reg.cor;
        end else if (g_upd) begin
            mem_vals[pidx_reg[fgm_pkg::GIDX_W-1:0]] <= item_reg.cor;
        end
        gval_rd_reg <= mem_vals[g_raddr];
    end

    // sequencer and result register
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            item_reg <= q_item;
        end
        if (issue) begin
            pidx_reg <= idx_reg;
        end
        if (done) begin
            out_status_reg     <= done_status;
            out_slot_valid_reg <= done_valid;
            out_fst_reg        <= done_valid ? gkey_rd_reg : '0;
            out_snd_reg        <= done_valid ? gpart_rd_reg : '0;
            out_cor_reg        <= done_valid ? gval_rd_reg : '0;
            out_groups_reg     <= gcount_next;
        end
        if (!aresetn) begin
            state_reg     <= fgm_pkg::ST_IDLE;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            mcount_reg    <= '0;
            gcount_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            gcount_reg <= gcount_next;
            mcount_reg <= mcount_reg + fgm_pkg::MCNT_W'(m_we);
            if (scan_clr) begin
                idx_reg  <= '0;
                pend_reg <= 1'b0;
            end else begin
                pend_reg <= issue;
                idx_reg  <= idx_reg + SW'(issue);
            end
            if (done) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = fgm_pkg::OUT_W'({out_groups_reg, out_cor_reg, out_snd_reg,
                                       out_fst_reg, out_slot_valid_reg, out_status_reg});
endmodule

>>> src/filtered_group_max_abs_select_top.sv
// Top level of the filtered group max-abs selector.
//
// Keeps a set of second-locus ids (op 0 loads one) and a table of first-locus
// groups holding the record with the largest |correlation| (op 1), readable by
// slot (op 2). Every input transfer gives exactly one result transfer. Op 0 and
// op 1 scan the member set linearly, one entry per cycle through its read port,
// and op 1, if its second locus is a member, then scans the group table the
// same way. The engine works one item at a time and pops the next only once
// the result register has been taken; a two-entry queue lets the input side
// keep taking transfers while the engine is busy, and a result register holds
// the last result until taken.
module filtered_group_max_abs_select_top (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // op, first_locus, second_locus, correlation, slot_index (from bit 0)
    input  logic [fgm_pkg::IN_W-1:0]   s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // status, slot_valid, out_first_locus, out_second_locus, out_correlation,
    // groups_used (from bit 0)
    output logic [fgm_pkg::OUT_W-1:0]  m_tdata
);
    fgm_pkg::item_t push_item, pop_item;
    logic push, full, pop, not_empty;

    fgm_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (full),
        .q_push   (push),
        .q_item   (push_item)
    );

    fgm_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .pop_item  (pop_item)
    );

    fgm_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (not_empty),
        .q_item   (pop_item),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );
endmodule

>>> src/fgm_checker.sv
// Port-level checks for the selector, bound to the top level.
module fgm_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [fgm_pkg::OUT_W-1:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_read_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] |-> m_tdata[1:0] == fgm_pkg::STAT_OK)
        else $error("valid slot read with nonzero status");

    a_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[2] |-> m_tdata[80:3] == '0)
        else $error("data fields set without a valid slot");

    a_groups: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> 32'(m_tdata[91:81]) <= fgm_pkg::GROUP_DEPTH)
        else $error("group count beyond table depth");
endmodule

bind filtered_group_max_abs_select_top fgm_checker u_fgm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> dv/tb.sv
// Testbench for filtered_group_max_abs_select_top: random and directed stream traffic.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ID_BITS      = fgm_pkg::ID_BITS;
    localparam int COR_BITS     = fgm_pkg::COR_BITS;
    localparam int SLOT_BITS    = fgm_pkg::SLOT_BITS;
    localparam int GCNT_W       = fgm_pkg::GCNT_W;
    localparam int IN_W         = fgm_pkg::IN_W;
    localparam int OUT_W        = fgm_pkg::OUT_W;
    localparam int MEMBER_DEPTH = fgm_pkg::MEMBER_DEPTH;
    localparam int GROUP_DEPTH  = fgm_pkg::GROUP_DEPTH;

    localparam logic [1:0] OP_LOAD       = fgm_pkg::OP_LOAD;
    localparam logic [1:0] OP_REC        = fgm_pkg::OP_REC;
    localparam logic [1:0] OP_READ       = fgm_pkg::OP_READ;
    localparam logic [1:0] STAT_FILTERED = fgm_pkg::STAT_FILTERED;
    localparam logic [1:0] STAT_GFULL    = fgm_pkg::STAT_GFULL;
    localparam logic [1:0] STAT_MFULL    = fgm_pkg::STAT_MFULL;

    localparam logic [1:0] OP_NOP = 2'd3;  // unused opcode; changes no state in the block but still gets a result
    localparam int LIMIT_CYCLES = 6_000_000;
    localparam int HOLD_CYCLES  = 400;

    typedef struct {
        logic [1:0]           op;
        logic [ID_BITS-1:0]   fst;
        logic [ID_BITS-1:0]   snd;
        logic [COR_BITS-1:0]  cor;
        logic [SLOT_BITS-1:0] slot;
    } req_t;

    typedef struct {
        logic [1:0]          status;
        logic                valid;
        logic [ID_BITS-1:0]  fst;
        logic [ID_BITS-1:0]  snd;
        logic [COR_BITS-1:0] cor;
        logic [GCNT_W-1:0]   used;
    } res_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;

    filtered_group_max_abs_select_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Items waiting to be driven, results waiting to come back.
    req_t pending[$];
    res_t expected_results[$];
    req_t cur_req;
    logic in_fire = 1'b0;
    int   src_idle = 0;
    int   snk_idle = 0;
    int   errors = 0;
    int   cycles = 0;
    bit   pressure_armed = 0;
    bit   pressure_done = 0;
    int   hold_left = 0;

    // Shadow of the block: member set and per-first-locus best record.
    logic [ID_BITS-1:0]  sh_members[$];
    logic [ID_BITS-1:0]  sh_keys[$];
    logic [ID_BITS-1:0]  sh_partners[$];
    logic [COR_BITS-1:0] sh_values[$];

    // Stimulus-side bookkeeping, ahead of the shadow.
    logic [ID_BITS-1:0]  gen_members[$];
    logic [ID_BITS-1:0]  gen_keys[$];
    bit                  member_seen[logic [ID_BITS-1:0]];
    bit                  key_seen[logic [ID_BITS-1:0]];

    function automatic int magnitude(logic [COR_BITS-1:0] c);
        int v;
        v = $signed(c);
        return (v < 0) ? -v : v;
    endfunction

    function automatic bit is_member(logic [ID_BITS-1:0] id);
        foreach (sh_members[i]) if (sh_members[i] == id) return 1;
        return 0;
    endfunction

    // Apply one item to the shadow and return the result it should produce.
    function automatic res_t best_record_step(req_t r);
        res_t e;
        int   g;
        e = '{default: '0};
        g = -1;
        case (r.op)
            OP_LOAD: begin
                if (!is_member(r.snd)) begin
                    if (sh_members.size() >= MEMBER_DEPTH) e.status = STAT_MFULL;
                    else sh_members.push_back(r.snd);
                end
            end
            OP_REC: begin
                if (!is_member(r.snd)) begin
                    e.status = STAT_FILTERED;
                end else begin
                    foreach (sh_keys[i]) if (g < 0 && sh_keys[i] == r.fst) g = i;
                    if (g >= 0) begin
                        // strictly larger magnitude wins; ties keep the old record
                        if (magnitude(r.cor) > magnitude(sh_values[g])) begin
                            sh_partners[g] = r.snd;
                            sh_values[g] = r.cor;
                        end
                    end else if (sh_keys.size() >= GROUP_DEPTH) begin
                        e.status = STAT_GFULL;
                    end else begin
                        sh_keys.push_back(r.fst);
                        sh_partners.push_back(r.snd);
                        sh_values.push_back(r.cor);
                    end
                end
            end
            OP_READ: begin
                if (int'(r.slot) < sh_keys.size()) begin
                    e.valid = 1'b1;
                    e.fst = sh_keys[r.slot];
                    e.snd = sh_partners[r.slot];
                    e.cor = sh_values[r.slot];
                end
            end
            default: ;
        endcase
        e.used = GCNT_W'(sh_keys.size());
        return e;
    endfunction

    function automatic logic [IN_W-1:0] pack_req(req_t r);
        return IN_W'({r.slot, r.cor, r.snd, r.fst, r.op});
    endfunction

    function automatic logic [ID_BITS-1:0] rand_id();
        return ID_BITS'($urandom);
    endfunction

    function automatic logic [COR_BITS-1:0] rand_cor();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h8001;
            default: return COR_BITS'($urandom);
        endcase
    endfunction

    task automatic queue_item(logic [1:0] op, logic [ID_BITS-1:0] fst, logic [ID_BITS-1:0] snd,
                              logic [COR_BITS-1:0] cor, logic [SLOT_BITS-1:0] slot);
        req_t r;
        r = '{op: op, fst: fst, snd: snd, cor: cor, slot: slot};
        if (op == OP_LOAD && !member_seen.exists(snd)) begin
            member_seen[snd] = 1;
            gen_members.push_back(snd);
        end
        pending.push_back(r);
    endtask

    // Fresh id not yet queued for loading as a member.
    function automatic logic [ID_BITS-1:0] fresh_member();
        logic [ID_BITS-1:0] id;
        do id = rand_id(); while (member_seen.exists(id));
        return id;
    endfunction

    task automatic queue_record(logic [ID_BITS-1:0] fst, logic [ID_BITS-1:0] snd,
                                logic [COR_BITS-1:0] cor);
        if (!key_seen.exists(fst) && member_seen.exists(snd)) begin
            key_seen[fst] = 1;
            gen_keys.push_back(fst);
        end
        queue_item(OP_REC, fst, snd, cor, SLOT_BITS'($urandom));
    endtask

    // Random mix kept to small tables so each item stays cheap.
    task automatic queue_random(int count);
        logic [ID_BITS-1:0] fst, snd;
        int pick;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 22) begin
                if (gen_members.size() > 0 && ($urandom_range(3) == 0 || gen_members.size() > 40))
                    snd = gen_members[$urandom_range(gen_members.size() - 1)];
                else
                    snd = fresh_member();
                queue_item(OP_LOAD, rand_id(), snd, COR_BITS'($urandom), SLOT_BITS'($urandom));
            end else if (pick < 75) begin
                if (gen_keys.size() > 0 && ($urandom_range(1) == 0 || gen_keys.size() > 60))
                    fst = gen_keys[$urandom_range(gen_keys.size() - 1)];
                else
                    fst = rand_id();
                if (gen_members.size() > 0 && $urandom_range(4) != 0)
                    snd = gen_members[$urandom_range(gen_members.size() - 1)];
                else
                    snd = rand_id();
                queue_record(fst, snd, rand_cor());
            end else if (pick < 92) begin
                queue_item(OP_READ, rand_id(), rand_id(), COR_BITS'($urandom),
                           ($urandom_range(3) == 0) ? SLOT_BITS'($urandom)
                                                    : SLOT_BITS'($urandom_range(gen_keys.size())));
            end else begin
                queue_item(OP_NOP, rand_id(), rand_id(), COR_BITS'($urandom), SLOT_BITS'($urandom));
            end
        end
    endtask

    task automatic wait_drain();
        do @(posedge aclk);
        while (pending.size() != 0 || s_tvalid || expected_results.size() != 0);
    endtask

    // Driver: a new transfer is offered once the previous one went through.
    always @(negedge aclk) begin
        req_t r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_fire) begin
            if (pending.size() > 0 && $urandom_range(99) >= src_idle) begin
                r = pending.pop_front();
                cur_req <= r;
                s_tdata <= pack_req(r);
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus one long hold-off to back up the block.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (pressure_armed && !pressure_done) begin
            pressure_done <= 1;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_idle);
        end
    end

    // Monitor: predict on each input transfer, check on each output transfer.
    always @(posedge aclk) begin
        res_t e;
        res_t got;
        cycles <= cycles + 1;
        in_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready)
            expected_results.push_back(best_record_step(cur_req));
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tdata[1:0];
            got.valid  = m_tdata[2];
            got.fst    = m_tdata[33:3];
            got.snd    = m_tdata[64:34];
            got.cor    = m_tdata[80:65];
            got.used   = m_tdata[91:81];
            if (expected_results.size() == 0) begin
                $error("unexpected result transfer, status %0d", got.status);
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (got.status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, got.status); errors++;
                end
                if (got.valid !== e.valid) begin
                    $error("slot_valid: expected %0d, got %0d", e.valid, got.valid); errors++;
                end
                if (got.fst !== e.fst) begin
                    $error("out_first_locus: expected %0h, got %0h", e.fst, got.fst); errors++;
                end
                if (got.snd !== e.snd) begin
                    $error("out_second_locus: expected %0h, got %0h", e.snd, got.snd); errors++;
                end
                if (got.cor !== e.cor) begin
                    $error("out_correlation: expected %0h, got %0h", e.cor, got.cor); errors++;
                end
                if (got.used !== e.used) begin
                    $error("groups_used: expected %0d, got %0d", e.used, got.used); errors++;
                end
            end
        end
        if (cycles > LIMIT_CYCLES) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: empty reads, id and correlation extremes, ties, filtering.
        src_idle = 23;
        snk_idle = 84;
        queue_item(OP_READ, '0, '0, '0, '0);
        queue_record('0, '0, '0);                     // no members yet: filtered
        queue_item(OP_LOAD, '0, '0, '0, '0);
        queue_item(OP_LOAD, '1, '1, '1, '1);
        queue_item(OP_LOAD, '0, '0, '0, '0);          // duplicate member
        queue_record('0, '0, '0);
        queue_record('1, '1, 16'h8000);               // most negative code
        queue_record('1, '0, 16'h7FFF);               // smaller magnitude, kept old
        queue_record('0, '1, 16'h8000);               // replaces zero
        queue_record('0, '0, 16'h8000);               // tie keeps old partner
        queue_record(31'h2AAA_AAAA, '1, 16'hFFFF);
        queue_record(31'h2AAA_AAAA, '0, 16'h0001);    // tie on magnitude 1
        queue_record(31'h5555_5555, 31'h1234_5678, 16'h7FFF); // non-member partner
        queue_item(OP_READ, '0, '0, '0, 10'd0);
        queue_item(OP_READ, '0, '0, '0, 10'd1);
        queue_item(OP_READ, '0, '0, '0, 10'd2);
        queue_item(OP_READ, '0, '0, '0, 10'd3);       // just past the last group
        queue_item(OP_READ, '1, '1, '1, '1);          // top slot, empty
        queue_item(OP_NOP, '1, '1, '1, '1);
        queue_item(OP_NOP, '0, '0, '0, '0);
        queue_random(85);
        wait_drain();

        src_idle = 84;
        snk_idle = 23;
        queue_random(85);
        wait_drain();

        // No idling; hold the receiver off while cheap reads pile up.
        src_idle = 0;
        snk_idle = 0;
        repeat (12) queue_item(OP_READ, rand_id(), rand_id(), '0, SLOT_BITS'($urandom_range(3)));
        pressure_armed = 1;
        queue_random(85);
        wait_drain();

        repeat (50) @(posedge aclk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
